[hdl/sgcq_pkg.sv]
// ----------------------------------------------------------------------------
// sgcq_pkg: shared types, codes and control store for the splice graph query
// Field widths, vertex kind and status codes, and the sequencer program.
// ----------------------------------------------------------------------------
package sgcq_pkg;

   localparam int MAX_VERTICES = 64;

   localparam int MODE_W  = 2;
   localparam int VTX_W   = 6;
   localparam int ROW_W   = 64;
   localparam int KIND_W  = 3;
   localparam int CLASS_W = 2;
   localparam int STAT_W  = 3;
   localparam int COUNT_W = 7;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

   // request modes
   localparam logic [MODE_W-1:0] MODE_WROW     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WKIND    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CASSETTE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_CLASSIFY = 2'd3;

   // vertex kinds
   localparam logic [KIND_W-1:0] KIND_HARD_START = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SOFT_START = 3'd1;
   localparam logic [KIND_W-1:0] KIND_HARD_END   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SOFT_END   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_UNUSED     = 3'd4;

   // edge classes
   localparam logic [CLASS_W-1:0] CLASS_EXON   = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_INTRON = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_OTHER  = 2'd2;

   // status codes
   localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_W-1:0] ST_NOT_START = 3'd1;
   localparam logic [STAT_W-1:0] ST_NOT_END   = 3'd2;
   localparam logic [STAT_W-1:0] ST_RANGE     = 3'd3;
   localparam logic [STAT_W-1:0] ST_NO_EDGE   = 3'd4;

   // read address select
   localparam int ASEL_W = 2;
   localparam logic [ASEL_W-1:0] ASEL_A = 2'd0;
   localparam logic [ASEL_W-1:0] ASEL_B = 2'd1;
   localparam logic [ASEL_W-1:0] ASEL_P = 2'd2;

   // datapath operations; each acts on the memory data read in the prior step
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_DONE      = 4'd0;
   localparam logic [OP_W-1:0] OP_NOP       = 4'd1;
   localparam logic [OP_W-1:0] OP_WROW      = 4'd2;
   localparam logic [OP_W-1:0] OP_WKIND     = 4'd3;
   localparam logic [OP_W-1:0] OP_CHK_START = 4'd4;
   localparam logic [OP_W-1:0] OP_CHK_END   = 4'd5;
   localparam logic [OP_W-1:0] OP_SCAN      = 4'd6;
   localparam logic [OP_W-1:0] OP_LOAD_A    = 4'd7;
   localparam logic [OP_W-1:0] OP_CLASSIFY  = 4'd8;

   // program counter and entry points
   localparam int PC_W = 4;
   localparam logic [PC_W-1:0] PC_DONE     = 4'd0;
   localparam logic [PC_W-1:0] PC_WROW     = 4'd1;
   localparam logic [PC_W-1:0] PC_WKIND    = 4'd2;
   localparam logic [PC_W-1:0] PC_CAS      = 4'd3;
   localparam logic [PC_W-1:0] PC_CAS_B    = 4'd4;
   localparam logic [PC_W-1:0] PC_CAS_SUCC = 4'd5;
   localparam logic [PC_W-1:0] PC_CAS_SCAN = 4'd6;
   localparam logic [PC_W-1:0] PC_CLS      = 4'd7;
   localparam logic [PC_W-1:0] PC_CLS_B    = 4'd8;
   localparam logic [PC_W-1:0] PC_CLS_EVAL = 4'd9;

   typedef struct packed {
      logic [ASEL_W-1:0] asel;
      logic [OP_W-1:0]   op;
      logic              loop;     // hold while scan rows remain to issue
      logic [PC_W-1:0]   next_pc;
   } ucode_type;

   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      w = '{asel: ASEL_A, op: OP_DONE, loop: 1'b0, next_pc: PC_DONE};
      unique case (pc)
         PC_WROW:     w = '{asel: ASEL_A, op: OP_WROW,      loop: 1'b0, next_pc: PC_DONE};
         PC_WKIND:    w = '{asel: ASEL_A, op: OP_WKIND,     loop: 1'b0, next_pc: PC_DONE};
         PC_CAS:      w = '{asel: ASEL_A, op: OP_NOP,       loop: 1'b0, next_pc: PC_CAS_B};
         PC_CAS_B:    w = '{asel: ASEL_B, op: OP_CHK_START, loop: 1'b0, next_pc: PC_CAS_SUCC};
         PC_CAS_SUCC: w = '{asel: ASEL_P, op: OP_CHK_END,   loop: 1'b0, next_pc: PC_CAS_SCAN};
         PC_CAS_SCAN: w = '{asel: ASEL_P, op: OP_SCAN,      loop: 1'b1, next_pc: PC_DONE};
         PC_CLS:      w = '{asel: ASEL_A, op: OP_NOP,       loop: 1'b0, next_pc: PC_CLS_B};
         PC_CLS_B:    w = '{asel: ASEL_B, op: OP_LOAD_A,    loop: 1'b0, next_pc: PC_CLS_EVAL};
         PC_CLS_EVAL: w = '{asel: ASEL_A, op: OP_CLASSIFY,  loop: 1'b0, next_pc: PC_DONE};
         default:     w = '{asel: ASEL_A, op: OP_DONE,      loop: 1'b0, next_pc: PC_DONE};
      endcase
      return w;
   endfunction

   function automatic logic is_start(input logic [KIND_W-1:0] k);
      return (k == KIND_HARD_START) || (k == KIND_SOFT_START);
   endfunction

   function automatic logic is_end(input logic [KIND_W-1:0] k);
      return (k == KIND_HARD_END) || (k == KIND_SOFT_END);
   endfunction

endpackage

[hdl/sgcq_req_if.sv]
// ----------------------------------------------------------------------------
// sgcq_req_if: request channel of the splice graph query block
// Valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface sgcq_req_if;
   logic                          valid;
   logic                          ready;
   logic [sgcq_pkg::MODE_W-1:0]   mode;
   logic [sgcq_pkg::VTX_W-1:0]    vertex_a;
   logic [sgcq_pkg::VTX_W-1:0]    vertex_b;
   logic [sgcq_pkg::ROW_W-1:0]    row_bits;
   logic [sgcq_pkg::KIND_W-1:0]   vertex_kind;

   modport source (output valid, mode, vertex_a, vertex_b, row_bits, vertex_kind,
                   input ready);
   modport sink   (input valid, mode, vertex_a, vertex_b, row_bits, vertex_kind,
                   output ready);
endinterface

[hdl/sgcq_rsp_if.sv]
// ----------------------------------------------------------------------------
// sgcq_rsp_if: response channel of the splice graph query block
// Valid/ready handshake with the response fields.
// ----------------------------------------------------------------------------
interface sgcq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          cassette;
   logic [sgcq_pkg::CLASS_W-1:0]  edge_class;
   logic [sgcq_pkg::STAT_W-1:0]   status;

   modport source (output valid, cassette, edge_class, status, input ready);
   modport sink   (input valid, cassette, edge_class, status, output ready);
endinterface

[hdl/sgcq_ram.sv]
// ----------------------------------------------------------------------------
// sgcq_ram: generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sgcq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[hdl/splice_graph_cassette_query_top.sv]
// ----------------------------------------------------------------------------
// splice_graph_cassette_query_top: splice graph store with cassette queries
// Adjacency rows and vertex kinds held in RAM, driven by a microcoded
// sequencer that runs one short program per request.
// ----------------------------------------------------------------------------
// Use:
//   req_ch carries one request: write an adjacency row, write a vertex kind,
//   run a cassette test or classify an edge. rsp_ch returns exactly one
//   response per request (cassette flag, edge class, status). csr_we/csr_wdata
//   set the live vertex count; write it only while no request is in flight.
// Flow:
//   index errors go straight to the response step; a cassette test stops
//   early when a kind check fails, else it runs the predecessor scan
//   that reads one adjacency row per cycle through the row RAM's single read port.
//   One request is worked on at a time; req_ch.ready rises again as the
//   response is loaded into the output register, so a new request is
//   taken while that response still waits.
// Reset: synchronous; clears the per-row valid bits, so the matrix reads as
//   empty and every kind as unused; the vertex count returns to 64.
// Stall: a held-off response stays in the output register; the sequencer
//   waits on its final step until that register frees up.
// ----------------------------------------------------------------------------
module splice_graph_cassette_query_top #(
   parameter int MAX_VERTICES = sgcq_pkg::MAX_VERTICES
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [sgcq_pkg::COUNT_W-1:0] csr_wdata,
   sgcq_req_if.sink                     req_ch,
   sgcq_rsp_if.source                   rsp_ch
);

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int PW = $clog2(MAX_VERTICES + 1);
   localparam int CW = sgcq_pkg::COUNT_W;

   // configuration
   logic [CW-1:0] count_ff;
   logic [CW-1:0] n_live;

   // latched request
   logic [sgcq_pkg::VTX_W-1:0]  a_ff;
   logic [sgcq_pkg::VTX_W-1:0]  b_ff;
   logic [MAX_VERTICES-1:0]     row_ff;
   logic [sgcq_pkg::KIND_W-1:0] kind_ff;

   // sequencer
   logic                      busy_ff;
   logic [sgcq_pkg::PC_W-1:0] pc_ff, pc_in;
   sgcq_pkg::ucode_type       cw;
   logic [PW-1:0]             p_ff;
   logic [PW-1:0]             p_rd_ff;
   logic                      scan_more;
   logic                      fail;
   logic                      done_fire;

   // working results
   logic                         cas_w_ff;
   logic [sgcq_pkg::CLASS_W-1:0] class_w_ff;
   logic [sgcq_pkg::STAT_W-1:0]  stat_w_ff;
   logic [MAX_VERTICES-1:0]      succ_ff;
   logic                         edge_bit_ff;
   logic [sgcq_pkg::KIND_W-1:0]  kind_a_ff;

   // output register
   logic                         rsp_valid_ff;
   logic                         rsp_cas_ff;
   logic [sgcq_pkg::CLASS_W-1:0] rsp_class_ff;
   logic [sgcq_pkg::STAT_W-1:0]  rsp_stat_ff;

   // memories and valid bits
   logic [MAX_VERTICES-1:0]     row_vld_ff;
   logic [MAX_VERTICES-1:0]     kind_vld_ff;
   logic                        rd_row_vld_ff;
   logic                        rd_kind_vld_ff;
   logic [AW-1:0]               raddr;
   logic [AW-1:0]               a_idx, b_idx;
   logic [MAX_VERTICES-1:0]     row_rdata, row_eff;
   logic [sgcq_pkg::KIND_W-1:0] kind_rdata, kind_eff;
   logic                        row_we, kind_we;
   logic [MAX_VERTICES-1:0]     succ_mask;

   logic                        req_fire;
   logic                        range_err;
   logic [sgcq_pkg::PC_W-1:0]   entry_pc;

   assign n_live = (count_ff > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : count_ff;

   assign a_idx = a_ff[AW-1:0];
   assign b_idx = b_ff[AW-1:0];

   assign req_ch.ready = !busy_ff;
   assign req_fire     = req_ch.valid && !busy_ff;

   always_comb begin
      range_err = (CW'(req_ch.vertex_a) >= n_live);
      if (req_ch.mode == sgcq_pkg::MODE_CASSETTE || req_ch.mode == sgcq_pkg::MODE_CLASSIFY) begin
         range_err = range_err || (CW'(req_ch.vertex_b) >= n_live);
      end
      unique case (req_ch.mode)
         sgcq_pkg::MODE_WROW:     entry_pc = sgcq_pkg::PC_WROW;
         sgcq_pkg::MODE_WKIND:    entry_pc = sgcq_pkg::PC_WKIND;
         sgcq_pkg::MODE_CASSETTE: entry_pc = sgcq_pkg::PC_CAS;
         sgcq_pkg::MODE_CLASSIFY: entry_pc = sgcq_pkg::PC_CLS;
         default:                 entry_pc = sgcq_pkg::PC_DONE;
      endcase
   end

   assign cw = sgcq_pkg::ucode_rom(pc_ff);

   always_comb begin
      unique case (cw.asel)
         sgcq_pkg::ASEL_A: raddr = a_idx;
         sgcq_pkg::ASEL_B: raddr = b_idx;
         sgcq_pkg::ASEL_P: raddr = p_ff[AW-1:0];
         default:          raddr = a_idx;
      endcase
   end

   // unwritten entries read as their reset values
   assign row_eff  = rd_row_vld_ff ? row_rdata : '0;
   assign kind_eff = rd_kind_vld_ff ? kind_rdata : sgcq_pkg::KIND_UNUSED;

   // successors of b inside the live range, b itself excluded
   always_comb begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
         succ_mask[i] = (CW'(i) < n_live) && (AW'(i) != b_idx);
      end
   end

   assign row_we    = busy_ff && (cw.op == sgcq_pkg::OP_WROW);
   assign kind_we   = busy_ff && (cw.op == sgcq_pkg::OP_WKIND);
   assign scan_more = (CW'(p_ff) != n_live);
   assign done_fire = busy_ff && (cw.op == sgcq_pkg::OP_DONE)
                      && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      fail = 1'b0;
      if (busy_ff && cw.op == sgcq_pkg::OP_CHK_START) begin
         fail = !sgcq_pkg::is_start(kind_eff);
      end else if (busy_ff && cw.op == sgcq_pkg::OP_CHK_END) begin
         fail = !sgcq_pkg::is_end(kind_eff);
      end
   end

   always_comb begin
      pc_in = pc_ff;
      if (fail) begin
         pc_in = sgcq_pkg::PC_DONE;
      end else if (cw.op == sgcq_pkg::OP_DONE) begin
         pc_in = pc_ff;
      end else if (cw.loop && scan_more) begin
         pc_in = pc_ff;
      end else begin
         pc_in = cw.next_pc;
      end
   end

   sgcq_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_row_ram (
      .clock (clock),
      .we    (row_we),
      .waddr (a_idx),
      .wdata (row_ff),
      .raddr (raddr),
      .rdata (row_rdata)
   );

   sgcq_ram #(.WIDTH(sgcq_pkg::KIND_W), .DEPTH(MAX_VERTICES)) u_kind_ram (
      .clock (clock),
      .we    (kind_we),
      .waddr (a_idx),
      .wdata (kind_ff),
      .raddr (raddr),
      .rdata (kind_rdata)
   );

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= sgcq_pkg::COUNT_RESET;
         busy_ff      <= 1'b0;
         pc_ff        <= sgcq_pkg::PC_DONE;
         rsp_valid_ff <= 1'b0;
         row_vld_ff   <= '0;
         kind_vld_ff  <= '0;
      end else begin
         if (csr_we) begin
            count_ff <= csr_wdata;
         end
         if (rsp_valid_ff && rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_fire) begin
            busy_ff <= 1'b1;
            pc_ff   <= range_err ? sgcq_pkg::PC_DONE : entry_pc;
         end else if (busy_ff) begin
            pc_ff <= pc_in;
            if (done_fire) begin
               busy_ff      <= 1'b0;
               rsp_valid_ff <= 1'b1;
            end
         end
         if (row_we) begin
            row_vld_ff[a_idx] <= 1'b1;
         end
         if (kind_we) begin
            kind_vld_ff[a_idx] <= 1'b1;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rd_row_vld_ff  <= row_vld_ff[raddr];
      rd_kind_vld_ff <= kind_vld_ff[raddr];
      p_rd_ff        <= p_ff;

      if (req_fire) begin
         a_ff       <= req_ch.vertex_a;
         b_ff       <= req_ch.vertex_b;
         row_ff     <= req_ch.row_bits[MAX_VERTICES-1:0];
         kind_ff    <= req_ch.vertex_kind;
         p_ff       <= '0;
         cas_w_ff   <= 1'b0;
         class_w_ff <= sgcq_pkg::CLASS_EXON;
         stat_w_ff  <= range_err ? sgcq_pkg::ST_RANGE : sgcq_pkg::ST_OK;
      end else if (busy_ff) begin
         if (cw.asel == sgcq_pkg::ASEL_P && scan_more) begin
            p_ff <= p_ff + PW'(1);
         end
         unique case (cw.op)
            sgcq_pkg::OP_CHK_START: begin
               if (fail) begin
                  stat_w_ff <= sgcq_pkg::ST_NOT_START;
               end
            end
            sgcq_pkg::OP_CHK_END: begin
               if (fail) begin
                  stat_w_ff <= sgcq_pkg::ST_NOT_END;
               end
               succ_ff <= row_eff & succ_mask;
            end
            sgcq_pkg::OP_SCAN: begin
               // predecessor p of a (p != a) reaching a successor of b
               if (CW'(p_rd_ff) != CW'(a_ff) && row_eff[a_idx] && |(row_eff & succ_ff)) begin
                  cas_w_ff <= 1'b1;
               end
            end
            sgcq_pkg::OP_LOAD_A: begin
               edge_bit_ff <= row_eff[b_idx];
               kind_a_ff   <= kind_eff;
            end
            sgcq_pkg::OP_CLASSIFY: begin
               if (!edge_bit_ff) begin
                  stat_w_ff <= sgcq_pkg::ST_NO_EDGE;
               end else if (sgcq_pkg::is_start(kind_a_ff) && sgcq_pkg::is_end(kind_eff)) begin
                  class_w_ff <= sgcq_pkg::CLASS_EXON;
               end else if (sgcq_pkg::is_end(kind_a_ff) && sgcq_pkg::is_start(kind_eff)) begin
                  class_w_ff <= sgcq_pkg::CLASS_INTRON;
               end else begin
                  class_w_ff <= sgcq_pkg::CLASS_OTHER;
               end
            end
            default: begin
            end
         endcase
      end

      if (done_fire) begin
         rsp_cas_ff   <= cas_w_ff;
         rsp_class_ff <= class_w_ff;
         rsp_stat_ff  <= stat_w_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.cassette   = rsp_cas_ff;
   assign rsp_ch.edge_class = rsp_class_ff;
   assign rsp_ch.status     = rsp_stat_ff;

endmodule
